/* rtl/core/time_of_day_text_parser_assert.svh */
// Assertion macros for the time-of-day parser.
// Each macro expects clk and rst_n in the scope of the module that uses it.
`ifndef TIME_OF_DAY_TEXT_PARSER_ASSERT_SVH
`define TIME_OF_DAY_TEXT_PARSER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define TODP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define TODP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/todp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package todp_pkg;

  // Parse phases, one-hot.
  typedef enum logic [6:0] {
    PH_LEAD     = 7'b0000001,
    PH_HOUR     = 7'b0000010,
    PH_MINUTE   = 7'b0000100,
    PH_SECOND   = 7'b0001000,
    PH_SUFFIX   = 7'b0010000,
    PH_SUFFIX_M = 7'b0100000,
    PH_SKIP     = 7'b1000000
  } todp_phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_RANGE  = 2'd2
  } todp_status_t;

  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;
  localparam logic [4:0] PM_OFFSET  = 5'd12;
  localparam logic [4:0] HOUR_NOON  = 5'd12;
  localparam logic [6:0] NUM_SAT    = 7'd127;

  typedef struct packed {
    todp_phase_t  phase;
    logic [6:0]   acc;
    logic         digit_seen;
    logic [4:0]   hour;
    logic [5:0]   minute;
    todp_status_t err;
  } todp_state_t;

  typedef struct packed {
    todp_status_t status;
    logic [4:0]   hour;
    logic [5:0]   minute;
    logic [5:0]   second;
  } todp_result_t;

  localparam todp_state_t STATE_RST = '{
    phase:      PH_LEAD,
    acc:        7'd0,
    digit_seen: 1'b0,
    hour:       5'd0,
    minute:     6'd0,
    err:        ST_OK
  };

endpackage

`default_nettype wire

/* rtl/core/time_of_day_text_parser.sv */
// Time-of-day text parser.
// Input channel: in_valid / in_ready with one text byte, in_char_in, per item.
// The first byte of a field is a lead byte; then H, H:MM or H:MM:SS, an
// optional a/p suffix and optional m. A NUL or whitespace byte ends the field
// and yields one result item on out_valid / out_ready: out_status (0 ok,
// 1 format error, 2 out of range), out_hour_out, out_minute_out and
// out_second_out. All other bytes yield no result.
// Path: a terminator byte goes through the input register, the combinational
// step logic and the result register.
// Throughput: one byte per cycle while the result register is free.
// Stall: while a result waits, one more byte is taken into the input register;
// further bytes are held off until out_ready frees the result register.
// Reset: synchronous, active low; both registers empty, parser waiting for a
// lead byte.
`timescale 1ns / 1ps
`default_nettype none
`include "time_of_day_text_parser_assert.svh"

module time_of_day_text_parser
  import todp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [4:0] out_hour_out,
  output logic [5:0] out_minute_out,
  output logic [5:0] out_second_out
);

  logic         in_vld_r;
  logic [7:0]   in_char_r;
  todp_state_t  state_r;
  todp_state_t  state_nxt;
  logic         step_res_vld;
  todp_result_t step_res;
  logic         slot_free;
  logic         proc_fire;
  todp_result_t out_data;

  assign proc_fire = in_vld_r && slot_free;
  assign in_ready  = !in_vld_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else if (proc_fire) begin
      state_r <= state_nxt;
    end
  end

  todp_step u_step (
    .st      (state_r),
    .ch      (in_char_r),
    .st_nxt  (state_nxt),
    .res_vld (step_res_vld),
    .res     (step_res)
  );

  todp_result_reg u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc_fire && step_res_vld),
    .load_data (step_res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_status     = out_data.status;
  assign out_hour_out   = out_data.hour;
  assign out_minute_out = out_data.minute;
  assign out_second_out = out_data.second;

  `TODP_ASSERT_ALWAYS(a_ok_in_range,
    !(out_valid && out_status == ST_OK) ||
    (out_hour_out <= HOUR_MAX[4:0] && out_minute_out <= MINSEC_MAX[5:0] &&
     out_second_out <= MINSEC_MAX[5:0]),
    "ok result with field out of range")
  `TODP_ASSERT_ALWAYS(a_err_zero_fields,
    !(out_valid && out_status != ST_OK) ||
    (out_hour_out == 5'd0 && out_minute_out == 6'd0 && out_second_out == 6'd0),
    "error result with nonzero fields")
  `TODP_ASSERT_NEXT(a_result_loaded, proc_fire && step_res_vld, out_valid,
    "result lost after terminator")
  `TODP_ASSERT_NEXT(a_back_to_lead, proc_fire && step_res_vld, state_r.phase == PH_LEAD,
    "parser not waiting for lead byte after result")

endmodule

`default_nettype wire

/* rtl/core/todp_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module todp_step
  import todp_pkg::*;
(
  input  todp_state_t  st,
  input  logic [7:0]   ch,
  output todp_state_t  st_nxt,
  output logic         res_vld,
  output todp_result_t res
);

  logic        term;
  logic        is_digit;
  logic [7:0]  lc;
  logic [10:0] acc_mac;
  logic [6:0]  acc_sat;
  logic [6:0]  limit;
  logic        in_range;
  logic [4:0]  hour_sel;
  logic [5:0]  minute_sel;
  logic [5:0]  second_sel;
  logic        fail;
  todp_status_t fail_code;

  assign term     = (ch == 8'd0) || (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign lc       = (ch >= CH_UC_A && ch <= CH_UC_Z) ? (ch | 8'h20) : ch;

  assign acc_mac  = ({4'd0, st.acc} << 3) + ({4'd0, st.acc} << 1) + {7'd0, ch[3:0]};
  assign acc_sat  = (acc_mac > {4'd0, NUM_SAT}) ? NUM_SAT : acc_mac[6:0];

  assign limit    = (st.phase == PH_HOUR) ? HOUR_MAX : MINSEC_MAX;
  assign in_range = (st.acc <= limit);

  // Values the number just closed leaves in the hold registers.
  assign hour_sel   = (st.phase == PH_HOUR) ? st.acc[4:0] : st.hour;
  assign minute_sel = (st.phase == PH_HOUR)   ? 6'd0 :
                      (st.phase == PH_MINUTE) ? st.acc[5:0] : st.minute;
  assign second_sel = (st.phase == PH_SECOND) ? st.acc[5:0] : 6'd0;

  always_comb begin
    st_nxt    = st;
    res_vld   = 1'b0;
    res       = '{status: ST_OK, hour: 5'd0, minute: 6'd0, second: 6'd0};
    fail      = 1'b0;
    fail_code = ST_FORMAT;

    unique case (st.phase)
      PH_HOUR, PH_MINUTE, PH_SECOND: begin
        if (is_digit) begin
          st_nxt.acc        = acc_sat;
          st_nxt.digit_seen = 1'b1;
        end else if (!st.digit_seen) begin
          fail = 1'b1;
        end else if (!in_range) begin
          fail      = 1'b1;
          fail_code = ST_RANGE;
        end else begin
          st_nxt.hour   = hour_sel;
          st_nxt.minute = minute_sel;
          st_nxt.acc    = (st.phase == PH_SECOND) ? st.acc : 7'd0;
          if (term) begin
            res_vld = 1'b1;
            res     = '{status: ST_OK, hour: hour_sel, minute: minute_sel,
                        second: second_sel};
            st_nxt  = STATE_RST;
          end else if (lc == CH_A) begin
            st_nxt.phase = PH_SUFFIX;
          end else if (lc == CH_P) begin
            if (hour_sel != 5'd0 && hour_sel < HOUR_NOON) begin
              st_nxt.hour = hour_sel + PM_OFFSET;
            end
            st_nxt.phase = PH_SUFFIX;
          end else if (ch == CH_COLON && st.phase != PH_SECOND) begin
            st_nxt.phase      = (st.phase == PH_HOUR) ? PH_MINUTE : PH_SECOND;
            st_nxt.acc        = 7'd0;
            st_nxt.digit_seen = 1'b0;
          end else begin
            fail = 1'b1;
          end
        end
      end
      PH_SUFFIX, PH_SUFFIX_M: begin
        if (term) begin
          res_vld = 1'b1;
          res     = '{status: ST_OK, hour: st.hour, minute: st.minute,
                      second: st.acc[5:0]};
          st_nxt  = STATE_RST;
        end else if (st.phase == PH_SUFFIX && lc == CH_M) begin
          st_nxt.phase = PH_SUFFIX_M;
        end else begin
          fail = 1'b1;
        end
      end
      PH_SKIP: begin
        if (term) begin
          res_vld    = 1'b1;
          res.status = st.err;
          st_nxt     = STATE_RST;
        end
      end
      default: begin
        // Consume the lead byte unseen.
        st_nxt       = STATE_RST;
        st_nxt.phase = PH_HOUR;
      end
    endcase

    // A terminator that causes the error reports at once.
    if (fail) begin
      if (term) begin
        res_vld    = 1'b1;
        res        = '{status: fail_code, hour: 5'd0, minute: 6'd0, second: 6'd0};
        st_nxt     = STATE_RST;
      end else begin
        st_nxt.err   = fail_code;
        st_nxt.phase = PH_SKIP;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/todp_result_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module todp_result_reg
  import todp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  todp_result_t load_data,
  output logic         slot_free,
  output logic         out_valid,
  input  logic         out_ready,
  output todp_result_t out_data
);

  logic         valid_r;
  todp_result_t data_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

/* tb/time_of_day_text_parser_checker.sv */
`timescale 1ns / 1ps

module time_of_day_text_parser_checker
  import todp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_status,
  input  logic [4:0] out_hour_out,
  input  logic [5:0] out_minute_out,
  input  logic [5:0] out_second_out,
  output int         mismatch_count,
  output int         pending_results,
  output int         results_seen,
  output int         format_errors_seen,
  output int         range_errors_seen
);

  // Parser state as predicted from the byte stream.
  todp_phase_t  phase;
  logic [6:0]   acc;
  logic         digit_seen;
  logic [4:0]   hour_q;
  logic [5:0]   minute_q;
  todp_status_t err_q;

  todp_result_t expected_times[$];

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t MISMATCH: %s", $realtime, msg);
  endtask

  task automatic clear_parse();
    phase      = PH_LEAD;
    acc        = '0;
    digit_seen = 1'b0;
    hour_q     = '0;
    minute_q   = '0;
    err_q      = ST_OK;
  endtask

  task automatic emit_time(input todp_status_t st, input logic [4:0] h,
                           input logic [5:0] m, input logic [5:0] s);
    todp_result_t r;
    r.status = st;
    r.hour   = h;
    r.minute = m;
    r.second = s;
    expected_times.push_back(r);
    clear_parse();
  endtask

  // Error at a terminator gives the result at once; otherwise skip to one.
  task automatic reject(input todp_status_t code, input logic term);
    if (term) begin
      emit_time(code, '0, '0, '0);
    end else begin
      err_q = code;
      phase = PH_SKIP;
    end
  endtask

  task automatic parse_byte(input logic [7:0] c);
    logic       term;
    logic [7:0] lc;
    logic [6:0] lim;
    int         v;
    term = (c == 8'h00) || (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    lc = (c >= CH_UC_A && c <= CH_UC_Z) ? (c | 8'h20) : c;
    case (phase)
      PH_HOUR, PH_MINUTE, PH_SECOND: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          v = int'(acc) * 10 + int'(c - CH_ZERO);
          acc = (v > int'(NUM_SAT)) ? NUM_SAT : v[6:0];
          digit_seen = 1'b1;
        end else if (!digit_seen) begin
          reject(ST_FORMAT, term);
        end else begin
          lim = (phase == PH_HOUR) ? HOUR_MAX : MINSEC_MAX;
          if (acc > lim) begin
            reject(ST_RANGE, term);
          end else begin
            if (phase == PH_HOUR) begin
              hour_q   = acc[4:0];
              minute_q = '0;
              acc      = '0;
            end else if (phase == PH_MINUTE) begin
              minute_q = acc[5:0];
              acc      = '0;
            end
            if (term) begin
              emit_time(ST_OK, hour_q, minute_q, acc[5:0]);
            end else if (lc == CH_A) begin
              phase = PH_SUFFIX;
            end else if (lc == CH_P) begin
              if (hour_q != 0 && hour_q < HOUR_NOON)
                hour_q = hour_q + PM_OFFSET;
              phase = PH_SUFFIX;
            end else if (c == CH_COLON && phase != PH_SECOND) begin
              if (phase == PH_HOUR)
                phase = PH_MINUTE;
              else
                phase = PH_SECOND;
              acc        = '0;
              digit_seen = 1'b0;
            end else begin
              reject(ST_FORMAT, term);
            end
          end
        end
      end
      PH_SUFFIX: begin
        if (term)
          emit_time(ST_OK, hour_q, minute_q, acc[5:0]);
        else if (lc == CH_M)
          phase = PH_SUFFIX_M;
        else
          reject(ST_FORMAT, term);
      end
      PH_SUFFIX_M: begin
        if (term)
          emit_time(ST_OK, hour_q, minute_q, acc[5:0]);
        else
          reject(ST_FORMAT, term);
      end
      PH_SKIP: begin
        if (term)
          emit_time(err_q, '0, '0, '0);
      end
      default: begin
        // lead byte: consume whatever it is
        clear_parse();
        phase = PH_HOUR;
      end
    endcase
  endtask

  always @(posedge clk) begin
    todp_result_t want;
    if (!rst_n) begin
      clear_parse();
      expected_times.delete();
      mismatch_count     = 0;
      results_seen       = 0;
      format_errors_seen = 0;
      range_errors_seen  = 0;
    end else begin
      // a result never comes from the byte taken at the same edge
      if (out_valid && out_ready) begin
        if (expected_times.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: status %0d %0d:%0d:%0d",
                                    out_status, out_hour_out, out_minute_out,
                                    out_second_out));
        end else begin
          want = expected_times.pop_front();
          results_seen++;
          if (want.status == ST_FORMAT) format_errors_seen++;
          if (want.status == ST_RANGE) range_errors_seen++;
          if (out_status !== want.status)
            report_mismatch($sformatf("result %0d status: got %0d, want %0d",
                                      results_seen, out_status, want.status));
          if (out_hour_out !== want.hour)
            report_mismatch($sformatf("result %0d hour: got %0d, want %0d",
                                      results_seen, out_hour_out, want.hour));
          if (out_minute_out !== want.minute)
            report_mismatch($sformatf("result %0d minute: got %0d, want %0d",
                                      results_seen, out_minute_out, want.minute));
          if (out_second_out !== want.second)
            report_mismatch($sformatf("result %0d second: got %0d, want %0d",
                                      results_seen, out_second_out, want.second));
        end
      end
      if (in_valid && in_ready)
        parse_byte(in_char_in);
    end
    pending_results = expected_times.size();
  end

endmodule

/* tb/time_of_day_text_parser_tb.sv */
`timescale 1ns / 1ps

module time_of_day_text_parser_tb;
  import todp_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int BYTE_TARGET  = 1300;
  localparam int MAX_GAP      = 10;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char_in;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_status;
  logic [4:0] out_hour_out;
  logic [5:0] out_minute_out;
  logic [5:0] out_second_out;

  int mismatch_count;
  int pending_results;
  int results_seen;
  int format_errors_seen;
  int range_errors_seen;

  logic       steady = 1'b0;
  logic [7:0] field_q[$];
  int         bytes_sent = 0;
  int         idle_cycles = 0;

  time_of_day_text_parser u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_hour_out   (out_hour_out),
    .out_minute_out (out_minute_out),
    .out_second_out (out_second_out)
  );

  time_of_day_text_parser_checker u_time_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_in         (in_char_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_hour_out       (out_hour_out),
    .out_minute_out     (out_minute_out),
    .out_second_out     (out_second_out),
    .mismatch_count     (mismatch_count),
    .pending_results    (pending_results),
    .results_seen       (results_seen),
    .format_errors_seen (format_errors_seen),
    .range_errors_seen  (range_errors_seen)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stop on a hang: count cycles with no item moving on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", IDLE_LIMIT);
      $display("time_of_day_text_parser verification failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (steady)
      return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic send_char(input logic [7:0] ch);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_char_in <= ch;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i]);
  endtask

  function automatic int pick_value(input int top);
    case ($urandom_range(0, 15))
      0:       return top;
      1:       return 0;
      2:       return top + 1 + $urandom_range(0, 8);
      3:       return $urandom_range(100, 99999);
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic logic [7:0] pick_terminator();
    case ($urandom_range(0, 2))
      0:       return 8'h00;
      1:       return CH_SPACE;
      default: return CH_TAB + 8'($urandom_range(0, 4));
    endcase
  endfunction

  task automatic push_number(input int val);
    logic [7:0] digits[$];
    int         rest;
    rest = val;
    if ($urandom_range(0, 5) == 0)
      field_q.push_back(CH_ZERO);
    do begin
      digits.push_front(CH_ZERO + 8'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    foreach (digits[i])
      field_q.push_back(digits[i]);
  endtask

  // One field: lead byte, mostly well-formed time text, then a terminator.
  task automatic build_field();
    int         kind;
    int         parts;
    int         pos;
    logic [7:0] sfx;
    field_q.delete();
    field_q.push_back(8'($urandom_range(0, 255)));
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 8))
        field_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      push_number(pick_value(HOUR_MAX));
      parts = $urandom_range(0, 2);
      if (parts >= 1) begin
        field_q.push_back(CH_COLON);
        push_number(pick_value(MINSEC_MAX));
      end
      if (parts == 2) begin
        field_q.push_back(CH_COLON);
        push_number(pick_value(MINSEC_MAX));
      end
      if (kind == 3) begin
        field_q.push_back(CH_COLON);
        push_number($urandom_range(0, 9));
      end
      sfx = ($urandom_range(0, 1) == 0) ? CH_A : CH_P;
      if ($urandom_range(0, 1) == 0)
        sfx = sfx ^ 8'h20;
      if ($urandom_range(0, 2) != 0) begin
        field_q.push_back(sfx);
        if ($urandom_range(0, 1) == 0)
          field_q.push_back(($urandom_range(0, 1) == 0) ? CH_M : (CH_M ^ 8'h20));
      end
      // corrupt a share of the fields
      if (kind == 1) begin
        pos = $urandom_range(1, field_q.size() - 1);
        field_q[pos] = 8'($urandom_range(0, 255));
      end else if (kind == 2) begin
        pos = $urandom_range(1, field_q.size());
        field_q.insert(pos, 8'($urandom_range(0, 255)));
      end
    end
    field_q.push_back(pick_terminator());
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_char_in = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // whitespace as lead, top of every range, upper-case pm on hour 23
    send_char(CH_TAB);
    send_text("23:59:59PM");
    send_char(8'h00);
    // noon with am stays 12
    send_char(8'hff);
    send_text("12a");
    send_char(CH_SPACE);
    // empty hour, then skip to the terminator
    send_text("q:9");
    send_char(CH_CR);
    // saturated hour, range error right at the terminator
    send_char(8'h80);
    send_text("200");
    send_char(8'h0b);
    // pm shift on a morning hour
    send_text("x7pm");
    send_char(8'h0c);

    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 11) == 0)
        steady = ~steady;
      build_field();
      foreach (field_q[i])
        send_char(field_q[i]);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d text bytes; checked %0d parsed times", bytes_sent, results_seen);
    $display("Of those, %0d ended in a format error and %0d in a range error",
             format_errors_seen, range_errors_seen);
    if (mismatch_count == 0 && pending_results == 0)
      $display("time_of_day_text_parser verification clean");
    else
      $display("time_of_day_text_parser verification failed");
    $finish;
  end

endmodule
